// ===== hw/rtl/ebwc_pkg.sv =====
// Shared types, codes and constants for the e-paper busy-line supervisor.
package ebwc_pkg;

    // Width of the elapsed-time counter; it saturates at its all-ones value.
    localparam int TIMER_BITS = 16;
    localparam int MS_W       = 16;
    localparam int CMP_W      = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [MS_W-1:0]       MS_MAX    = {MS_W{1'b1}};

    // Register reset values
    localparam logic [MS_W-1:0] HOOK_THRESHOLD_RST = MS_W'(1000);
    localparam logic [MS_W-1:0] TIMEOUT_RST        = MS_W'(30000);
    localparam logic [MS_W-1:0] GRACE_RST          = MS_W'(100);
    localparam logic [MS_W-1:0] FIRST_PHASE_RST    = MS_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOOK_THRESHOLD = 3'd0,
        CFG_TIMEOUT        = 3'd1,
        CFG_GRACE          = 3'd2,
        CFG_FIRST_PHASE    = 3'd3,
        CFG_BEGIN_HOOK     = 3'd4,
        CFG_END_HOOK       = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        MODE_ACTIVE_HIGH = 2'd0,
        MODE_ACTIVE_LOW  = 2'd1,
        MODE_IDLE_HIGH   = 2'd2,
        MODE_TWO_PHASE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_REL     = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_NEVER   = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_AH_LOOP   = 8'b0000_0010,
        PH_AL_GRACE  = 8'b0000_0100,
        PH_AL_LOOP   = 8'b0000_1000,
        PH_IH_SETTLE = 8'b0001_0000,
        PH_IH_LOOP   = 8'b0010_0000,
        PH_TP_EDGE   = 8'b0100_0000,
        PH_TP_LOOP   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_status         status;
        logic            begin_pulse;
        logic            end_pulse;
        logic [MS_W-1:0] elapsed;
    } t_result;

endpackage

// ===== hw/rtl/epaper_busy_wait_controller.sv =====
// Busy-line supervisor: start/tick request channel, status result channel.
//
// Usage: a start request (command 0) opens a wait in the mode given by
// wait_mode, with busy_level as the first sample. Each tick request
// (command 1) stands for one millisecond and carries the sampled busy level.
// Every request gives exactly one result: status (waiting, released, timed
// out, never asserted), begin/end hook pulses and the saturated elapsed time.
// One request is taken every cycle while o_in_stall is low. The result sits
// in an output register with a one-entry skid register behind it, so a
// request is still taken while a result waits; o_in_stall rises only when
// both are full. The state update is a single pass of compares and one
// counter increment. Configuration writes are registered; the user must make
// them only while no wait is being serviced; the block does not enforce it.
// Reset puts the block idle with the held status "released", elapsed zero,
// the registers at their documented defaults and both result stages empty.
module epaper_busy_wait_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [ebwc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ebwc_pkg::MS_W-1:0]         i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [1:0]                        i_wait_mode,
    input  logic                              i_busy_level,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic                              o_begin_hook_pulse,
    output logic                              o_end_hook_pulse,
    output logic [ebwc_pkg::MS_W-1:0]         o_elapsed_ms
);

    localparam int TB = ebwc_pkg::TIMER_BITS;
    localparam int CW = ebwc_pkg::CMP_W;
    localparam int MW = ebwc_pkg::MS_W;

    // configuration registers
    logic [MW-1:0] r_hook_threshold;
    logic [MW-1:0] r_timeout;
    logic [MW-1:0] r_grace;
    logic [MW-1:0] r_first_phase;
    logic          r_begin_present;
    logic          r_end_present;

    // wait state
    ebwc_pkg::t_phase  r_phase,  n_phase;
    logic [TB-1:0]     r_elapsed, n_elapsed;
    logic              r_long,    n_long;
    logic              r_hook,    n_hook;
    ebwc_pkg::t_status r_held,    n_held;

    // result stages
    logic              r_out_valid;
    logic              r_skid_valid;
    ebwc_pkg::t_result r_out;
    ebwc_pkg::t_result r_skid;
    ebwc_pkg::t_result n_res;

    logic          accept;
    logic          out_take;
    logic [TB-1:0] elapsed_inc;
    logic [CW-1:0] inc_cmp;
    logic [CW-1:0] n_elapsed_cmp;
    logic          loop_long;
    logic          loop_hook;
    logic          busy_high;

    assign accept     = i_in_valid & ~o_in_stall;
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign busy_high  = i_busy_level;

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hook_threshold <= ebwc_pkg::HOOK_THRESHOLD_RST;
            r_timeout        <= ebwc_pkg::TIMEOUT_RST;
            r_grace          <= ebwc_pkg::GRACE_RST;
            r_first_phase    <= ebwc_pkg::FIRST_PHASE_RST;
            r_begin_present  <= 1'b0;
            r_end_present    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ebwc_pkg::CFG_HOOK_THRESHOLD: r_hook_threshold <= i_cfg_data;
                ebwc_pkg::CFG_TIMEOUT:        r_timeout        <= i_cfg_data;
                ebwc_pkg::CFG_GRACE:          r_grace          <= i_cfg_data;
                ebwc_pkg::CFG_FIRST_PHASE:    r_first_phase    <= i_cfg_data;
                ebwc_pkg::CFG_BEGIN_HOOK:     r_begin_present  <= i_cfg_data[0];
                ebwc_pkg::CFG_END_HOOK:       r_end_present    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturating increment and the long-wait check shared by the loop phases
    assign elapsed_inc = (r_elapsed == ebwc_pkg::TIMER_MAX) ? r_elapsed
                                                             : r_elapsed + TB'(1);
    assign inc_cmp     = CW'(elapsed_inc);
    assign loop_long   = ~r_long & (inc_cmp > CW'(r_hook_threshold));
    assign loop_hook   = r_hook | (loop_long & r_begin_present);

    always_comb begin
        n_phase           = r_phase;
        n_elapsed         = r_elapsed;
        n_long            = r_long;
        n_hook            = r_hook;
        n_held            = r_held;
        n_res.status      = ebwc_pkg::ST_WAIT;
        n_res.begin_pulse = 1'b0;
        n_res.end_pulse   = 1'b0;

        if (i_command == ebwc_pkg::CMD_START) begin
            n_elapsed = '0;
            n_long    = 1'b0;
            n_hook    = 1'b0;
            case (i_wait_mode)
                ebwc_pkg::MODE_ACTIVE_HIGH: begin
                    if (busy_high) begin
                        n_phase = ebwc_pkg::PH_AH_LOOP;
                    end else begin
                        n_phase      = ebwc_pkg::PH_IDLE;
                        n_held       = ebwc_pkg::ST_REL;
                        n_res.status = ebwc_pkg::ST_REL;
                    end
                end
                ebwc_pkg::MODE_ACTIVE_LOW: begin
                    if (!busy_high) begin
                        n_phase = ebwc_pkg::PH_AL_LOOP;
                    end else if (r_grace != '0) begin
                        n_phase = ebwc_pkg::PH_AL_GRACE;
                    end else begin
                        n_phase      = ebwc_pkg::PH_IDLE;
                        n_held       = ebwc_pkg::ST_NEVER;
                        n_res.status = ebwc_pkg::ST_NEVER;
                    end
                end
                ebwc_pkg::MODE_IDLE_HIGH: n_phase = ebwc_pkg::PH_IH_SETTLE;
                default: n_phase = busy_high ? ebwc_pkg::PH_TP_EDGE
                                             : ebwc_pkg::PH_TP_LOOP;
            endcase
        end else if (r_phase == ebwc_pkg::PH_IDLE) begin
            n_res.status = r_held;
        end else begin
            n_elapsed = elapsed_inc;
            unique case (r_phase)
                ebwc_pkg::PH_AH_LOOP, ebwc_pkg::PH_AL_LOOP,
                ebwc_pkg::PH_TP_LOOP, ebwc_pkg::PH_IH_LOOP: begin
                    n_long            = r_long | loop_long;
                    n_hook            = loop_hook;
                    n_res.begin_pulse = loop_long & r_begin_present;
                    if (r_phase != ebwc_pkg::PH_IH_LOOP &&
                        inc_cmp > CW'(r_timeout)) begin
                        n_phase         = ebwc_pkg::PH_IDLE;
                        n_held          = ebwc_pkg::ST_TIMEOUT;
                        n_res.status    = ebwc_pkg::ST_TIMEOUT;
                        n_res.end_pulse = loop_hook & r_end_present;
                    end else if ((r_phase == ebwc_pkg::PH_AH_LOOP) ? !busy_high
                                                                   : busy_high) begin
                        n_phase         = ebwc_pkg::PH_IDLE;
                        n_held          = ebwc_pkg::ST_REL;
                        n_res.status    = ebwc_pkg::ST_REL;
                        n_res.end_pulse = loop_hook & r_end_present;
                    end
                end
                ebwc_pkg::PH_AL_GRACE: begin
                    if (inc_cmp < CW'(r_grace)) begin
                        if (!busy_high) n_phase = ebwc_pkg::PH_AL_LOOP;
                    end else begin
                        n_phase         = ebwc_pkg::PH_IDLE;
                        n_held          = ebwc_pkg::ST_NEVER;
                        n_res.status    = ebwc_pkg::ST_NEVER;
                        n_res.end_pulse = r_hook & r_end_present;
                    end
                end
                ebwc_pkg::PH_IH_SETTLE: begin
                    if (busy_high) begin
                        n_phase         = ebwc_pkg::PH_IDLE;
                        n_held          = ebwc_pkg::ST_REL;
                        n_res.status    = ebwc_pkg::ST_REL;
                        n_res.end_pulse = r_hook & r_end_present;
                    end else begin
                        n_phase = ebwc_pkg::PH_IH_LOOP;
                    end
                end
                default: begin // first phase of two-phase: wait for low edge
                    if (!busy_high) begin
                        n_phase = ebwc_pkg::PH_TP_LOOP;
                    end else if (inc_cmp > CW'(r_first_phase)) begin
                        n_phase         = ebwc_pkg::PH_IDLE;
                        n_held          = ebwc_pkg::ST_NEVER;
                        n_res.status    = ebwc_pkg::ST_NEVER;
                        n_res.end_pulse = r_hook & r_end_present;
                    end
                end
            endcase
        end

        n_elapsed_cmp = CW'(n_elapsed);
        n_res.elapsed = (n_elapsed_cmp > CW'(ebwc_pkg::MS_MAX)) ? ebwc_pkg::MS_MAX
                                                                : MW'(n_elapsed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ebwc_pkg::PH_IDLE;
            r_elapsed <= '0;
            r_long    <= 1'b0;
            r_hook    <= 1'b0;
            r_held    <= ebwc_pkg::ST_REL;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_long    <= n_long;
            r_hook    <= n_hook;
            r_held    <= n_held;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
                if (r_skid_valid) begin
                    r_out  <= r_skid;
                    r_skid <= n_res;
                end else begin
                    r_out <= n_res;
                end
            end else begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_begin_hook_pulse = r_out.begin_pulse;
    assign o_end_hook_pulse   = r_out.end_pulse;
    assign o_elapsed_ms       = r_out.elapsed;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_start_clears_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == ebwc_pkg::CMD_START) |=> (r_elapsed == '0))
        else $error("start request did not clear elapsed time");

    a_hook_needs_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hook |-> r_long)
        else $error("begin hook marked without a long wait");

    a_idle_tick_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == ebwc_pkg::CMD_TICK && r_phase == ebwc_pkg::PH_IDLE)
        |=> $stable(r_elapsed))
        else $error("tick while idle moved elapsed time");
`endif

endmodule
